// ===== src/opcode_stream_disassembler_assert.svh =====
// ----------------------------------------------------------------------------
// Opcode stream disassembler - assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef OPCODE_STREAM_DISASSEMBLER_ASSERT_SVH
`define OPCODE_STREAM_DISASSEMBLER_ASSERT_SVH

// same-cycle implication
`define OSD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/osd_pkg.sv =====
// ----------------------------------------------------------------------------
// osd_pkg
// Types, codes and the opcode decode table of the opcode stream disassembler.
// ----------------------------------------------------------------------------
package osd_pkg;

	typedef enum logic [5:0] {
		MN_ADC, MN_AND, MN_ASL, MN_BCC, MN_BCS, MN_BEQ, MN_BIT, MN_BMI,
		MN_BNE, MN_BPL, MN_BRK, MN_BVC, MN_BVS, MN_CLC, MN_CLD, MN_CLI,
		MN_CLV, MN_CMP, MN_CPX, MN_CPY, MN_DEC, MN_DEX, MN_DEY, MN_EOR,
		MN_INC, MN_INX, MN_INY, MN_JMP, MN_JSR, MN_LDA, MN_LDX, MN_LDY,
		MN_LSR, MN_NOP, MN_ORA, MN_PHA, MN_PHP, MN_PLA, MN_PLP, MN_ROL,
		MN_ROR, MN_RTI, MN_RTS, MN_SBC, MN_SEC, MN_SED, MN_SEI, MN_STA,
		MN_STX, MN_STY, MN_TAX, MN_TAY, MN_TSX, MN_TXA, MN_TXS, MN_TYA,
		MN_INVALID
	} mnem_t;

	typedef enum logic [3:0] {
		AM_IMPLIED, AM_IMMED, AM_ACC, AM_REL, AM_ZP, AM_ZPX, AM_ZPY,
		AM_ABS, AM_ABSX, AM_ABSY, AM_IND, AM_INDX, AM_INDY
	} mode_t;

	typedef struct packed {
		logic  legal;
		mnem_t mnem;
		mode_t mode;
	} decode_t;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       run_start;
		logic       run_end;
	} item_t;

	typedef struct packed {
		logic [15:0] opcode_address;
		mnem_t       mnem;
		mode_t       mode;
		logic [15:0] argument;
		logic        truncated;
	} rec_t;

	function automatic logic [1:0] operand_count(input mode_t md);
		logic [1:0] n;
		if (md inside {AM_IMPLIED, AM_ACC}) begin
			n = 2'd0;
		end else if (md inside {[AM_ABS:AM_IND]}) begin
			n = 2'd2;
		end else begin
			n = 2'd1;
		end
		return n;
	endfunction

	function automatic decode_t op_decode(input logic [7:0] op);
		decode_t d;
		case (op)
			8'h69: d = '{1'b1, MN_ADC, AM_IMMED};
			8'h65: d = '{1'b1, MN_ADC, AM_ZP};
			8'h75: d = '{1'b1, MN_ADC, AM_ZPX};
			8'h6d: d = '{1'b1, MN_ADC, AM_ABS};
			8'h7d: d = '{1'b1, MN_ADC, AM_ABSX};
			8'h79: d = '{1'b1, MN_ADC, AM_ABSY};
			8'h61: d = '{1'b1, MN_ADC, AM_INDX};
			8'h71: d = '{1'b1, MN_ADC, AM_INDY};
			8'h29: d = '{1'b1, MN_AND, AM_IMMED};
			8'h25: d = '{1'b1, MN_AND, AM_ZP};
			8'h35: d = '{1'b1, MN_AND, AM_ZPX};
			8'h2d: d = '{1'b1, MN_AND, AM_ABS};
			8'h3d: d = '{1'b1, MN_AND, AM_ABSX};
			8'h39: d = '{1'b1, MN_AND, AM_ABSY};
			8'h21: d = '{1'b1, MN_AND, AM_INDX};
			8'h31: d = '{1'b1, MN_AND, AM_INDY};
			8'h0a: d = '{1'b1, MN_ASL, AM_ACC};
			8'h06: d = '{1'b1, MN_ASL, AM_ZP};
			8'h16: d = '{1'b1, MN_ASL, AM_ZPX};
			8'h0e: d = '{1'b1, MN_ASL, AM_ABS};
			8'h1e: d = '{1'b1, MN_ASL, AM_ABSX};
			8'h90: d = '{1'b1, MN_BCC, AM_REL};
			8'hb0: d = '{1'b1, MN_BCS, AM_REL};
			8'hf0: d = '{1'b1, MN_BEQ, AM_REL};
			8'h24: d = '{1'b1, MN_BIT, AM_ZP};
			8'h2c: d = '{1'b1, MN_BIT, AM_ABS};
			8'h30: d = '{1'b1, MN_BMI, AM_REL};
			8'hd0: d = '{1'b1, MN_BNE, AM_REL};
			8'h10: d = '{1'b1, MN_BPL, AM_REL};
			8'h00: d = '{1'b1, MN_BRK, AM_IMPLIED};
			8'h50: d = '{1'b1, MN_BVC, AM_REL};
			8'h70: d = '{1'b1, MN_BVS, AM_REL};
			8'h18: d = '{1'b1, MN_CLC, AM_IMPLIED};
			8'hd8: d = '{1'b1, MN_CLD, AM_IMPLIED};
			8'h58: d = '{1'b1, MN_CLI, AM_IMPLIED};
			8'hb8: d = '{1'b1, MN_CLV, AM_IMPLIED};
			8'hc9: d = '{1'b1, MN_CMP, AM_IMMED};
			8'hc5: d = '{1'b1, MN_CMP, AM_ZP};
			8'hd5: d = '{1'b1, MN_CMP, AM_ZPX};
			8'hcd: d = '{1'b1, MN_CMP, AM_ABS};
			8'hdd: d = '{1'b1, MN_CMP, AM_ABSX};
			8'hd9: d = '{1'b1, MN_CMP, AM_ABSY};
			8'hc1: d = '{1'b1, MN_CMP, AM_INDX};
			8'hd1: d = '{1'b1, MN_CMP, AM_INDY};
			8'he0: d = '{1'b1, MN_CPX, AM_IMMED};
			8'he4: d = '{1'b1, MN_CPX, AM_ZP};
			8'hec: d = '{1'b1, MN_CPX, AM_ABS};
			8'hc0: d = '{1'b1, MN_CPY, AM_IMMED};
			8'hc4: d = '{1'b1, MN_CPY, AM_ZP};
			8'hcc: d = '{1'b1, MN_CPY, AM_ABS};
			8'hc6: d = '{1'b1, MN_DEC, AM_ZP};
			8'hd6: d = '{1'b1, MN_DEC, AM_ZPX};
			8'hce: d = '{1'b1, MN_DEC, AM_ABS};
			8'hde: d = '{1'b1, MN_DEC, AM_ABSX};
			8'hca: d = '{1'b1, MN_DEX, AM_IMPLIED};
			8'h88: d = '{1'b1, MN_DEY, AM_IMPLIED};
			8'h49: d = '{1'b1, MN_EOR, AM_IMMED};
			8'h45: d = '{1'b1, MN_EOR, AM_ZP};
			8'h55: d = '{1'b1, MN_EOR, AM_ZPX};
			8'h4d: d = '{1'b1, MN_EOR, AM_ABS};
			8'h5d: d = '{1'b1, MN_EOR, AM_ABSX};
			8'h59: d = '{1'b1, MN_EOR, AM_ABSY};
			8'h41: d = '{1'b1, MN_EOR, AM_INDX};
			8'h51: d = '{1'b1, MN_EOR, AM_INDY};
			8'he6: d = '{1'b1, MN_INC, AM_ZP};
			8'hf6: d = '{1'b1, MN_INC, AM_ZPX};
			8'hee: d = '{1'b1, MN_INC, AM_ABS};
			8'hfe: d = '{1'b1, MN_INC, AM_ABSX};
			8'he8: d = '{1'b1, MN_INX, AM_IMPLIED};
			8'hc8: d = '{1'b1, MN_INY, AM_IMPLIED};
			8'h4c: d = '{1'b1, MN_JMP, AM_ABS};
			8'h6c: d = '{1'b1, MN_JMP, AM_IND};
			8'h20: d = '{1'b1, MN_JSR, AM_ABS};
			8'ha9: d = '{1'b1, MN_LDA, AM_IMMED};
			8'ha5: d = '{1'b1, MN_LDA, AM_ZP};
			8'hb5: d = '{1'b1, MN_LDA, AM_ZPX};
			8'had: d = '{1'b1, MN_LDA, AM_ABS};
			8'hbd: d = '{1'b1, MN_LDA, AM_ABSX};
			8'hb9: d = '{1'b1, MN_LDA, AM_ABSY};
			8'ha1: d = '{1'b1, MN_LDA, AM_INDX};
			8'hb1: d = '{1'b1, MN_LDA, AM_INDY};
			8'ha2: d = '{1'b1, MN_LDX, AM_IMMED};
			8'ha6: d = '{1'b1, MN_LDX, AM_ZP};
			8'hb6: d = '{1'b1, MN_LDX, AM_ZPY};
			8'hae: d = '{1'b1, MN_LDX, AM_ABS};
			8'hbe: d = '{1'b1, MN_LDX, AM_ABSY};
			8'ha0: d = '{1'b1, MN_LDY, AM_IMMED};
			8'ha4: d = '{1'b1, MN_LDY, AM_ZP};
			8'hb4: d = '{1'b1, MN_LDY, AM_ZPX};
			8'hac: d = '{1'b1, MN_LDY, AM_ABS};
			8'hbc: d = '{1'b1, MN_LDY, AM_ABSX};
			8'h4a: d = '{1'b1, MN_LSR, AM_ACC};
			8'h46: d = '{1'b1, MN_LSR, AM_ZP};
			8'h56: d = '{1'b1, MN_LSR, AM_ZPX};
			8'h4e: d = '{1'b1, MN_LSR, AM_ABS};
			8'h5e: d = '{1'b1, MN_LSR, AM_ABSX};
			8'hea: d = '{1'b1, MN_NOP, AM_IMPLIED};
			8'h09: d = '{1'b1, MN_ORA, AM_IMMED};
			8'h05: d = '{1'b1, MN_ORA, AM_ZP};
			8'h15: d = '{1'b1, MN_ORA, AM_ZPX};
			8'h0d: d = '{1'b1, MN_ORA, AM_ABS};
			8'h1d: d = '{1'b1, MN_ORA, AM_ABSX};
			8'h19: d = '{1'b1, MN_ORA, AM_ABSY};
			8'h01: d = '{1'b1, MN_ORA, AM_INDX};
			8'h11: d = '{1'b1, MN_ORA, AM_INDY};
			8'h48: d = '{1'b1, MN_PHA, AM_IMPLIED};
			8'h08: d = '{1'b1, MN_PHP, AM_IMPLIED};
			8'h68: d = '{1'b1, MN_PLA, AM_IMPLIED};
			8'h28: d = '{1'b1, MN_PLP, AM_IMPLIED};
			8'h2a: d = '{1'b1, MN_ROL, AM_ACC};
			8'h26: d = '{1'b1, MN_ROL, AM_ZP};
			8'h36: d = '{1'b1, MN_ROL, AM_ZPX};
			8'h2e: d = '{1'b1, MN_ROL, AM_ABS};
			8'h3e: d = '{1'b1, MN_ROL, AM_ABSX};
			8'h6a: d = '{1'b1, MN_ROR, AM_ACC};
			8'h66: d = '{1'b1, MN_ROR, AM_ZP};
			8'h76: d = '{1'b1, MN_ROR, AM_ZPX};
			8'h6e: d = '{1'b1, MN_ROR, AM_ABS};
			8'h7e: d = '{1'b1, MN_ROR, AM_ABSX};
			8'h40: d = '{1'b1, MN_RTI, AM_IMPLIED};
			8'h60: d = '{1'b1, MN_RTS, AM_IMPLIED};
			8'he9: d = '{1'b1, MN_SBC, AM_IMMED};
			8'he5: d = '{1'b1, MN_SBC, AM_ZP};
			8'hf5: d = '{1'b1, MN_SBC, AM_ZPX};
			8'hed: d = '{1'b1, MN_SBC, AM_ABS};
			8'hfd: d = '{1'b1, MN_SBC, AM_ABSX};
			8'hf9: d = '{1'b1, MN_SBC, AM_ABSY};
			8'he1: d = '{1'b1, MN_SBC, AM_INDX};
			8'hf1: d = '{1'b1, MN_SBC, AM_INDY};
			8'h38: d = '{1'b1, MN_SEC, AM_IMPLIED};
			8'hf8: d = '{1'b1, MN_SED, AM_IMPLIED};
			8'h78: d = '{1'b1, MN_SEI, AM_IMPLIED};
			8'h85: d = '{1'b1, MN_STA, AM_ZP};
			8'h95: d = '{1'b1, MN_STA, AM_ZPX};
			8'h8d: d = '{1'b1, MN_STA, AM_ABS};
			8'h9d: d = '{1'b1, MN_STA, AM_ABSX};
			8'h99: d = '{1'b1, MN_STA, AM_ABSY};
			8'h81: d = '{1'b1, MN_STA, AM_INDX};
			8'h91: d = '{1'b1, MN_STA, AM_INDY};
			8'h86: d = '{1'b1, MN_STX, AM_ZP};
			8'h96: d = '{1'b1, MN_STX, AM_ZPY};
			8'h8e: d = '{1'b1, MN_STX, AM_ABS};
			8'h84: d = '{1'b1, MN_STY, AM_ZP};
			8'h94: d = '{1'b1, MN_STY, AM_ZPX};
			8'h8c: d = '{1'b1, MN_STY, AM_ABS};
			8'haa: d = '{1'b1, MN_TAX, AM_IMPLIED};
			8'ha8: d = '{1'b1, MN_TAY, AM_IMPLIED};
			8'hba: d = '{1'b1, MN_TSX, AM_IMPLIED};
			8'h8a: d = '{1'b1, MN_TXA, AM_IMPLIED};
			8'h9a: d = '{1'b1, MN_TXS, AM_IMPLIED};
			8'h98: d = '{1'b1, MN_TYA, AM_IMPLIED};
			default: d = '{1'b0, MN_INVALID, AM_IMPLIED};
		endcase
		return d;
	endfunction

endpackage

// ===== src/osd_decode_rom.sv =====
// ----------------------------------------------------------------------------
// osd_decode_rom
// 256-entry opcode decode ROM with a registered read port.
// ----------------------------------------------------------------------------
module osd_decode_rom (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [7:0]       rd_addr,
	output osd_pkg::decode_t rd_data
);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= osd_pkg::op_decode(rd_addr);
		end
	end

endmodule

// ===== src/osd_record_seq.sv =====
// ----------------------------------------------------------------------------
// osd_record_seq
// Operand byte sequencer and result register: gathers operand bytes behind
// each decoded opcode and emits complete or truncated records.
// ----------------------------------------------------------------------------
`include "opcode_stream_disassembler_assert.svh"

module osd_record_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [15:0]      start_address,
	input  logic             valid_s1,
	input  osd_pkg::item_t   item_s1,
	input  osd_pkg::decode_t dec_s1,
	output logic             advance,
	output logic             rec_valid,
	input  logic             rec_stall,
	output osd_pkg::rec_t    rec
);

	logic [1:0]     pending_q;
	osd_pkg::mnem_t held_mn_q;
	osd_pkg::mode_t held_mode_q;
	logic [7:0]     held_low_q;
	logic [15:0]    next_addr_q;
	logic [15:0]    held_addr_q;

	logic [1:0]     pend_eff;
	logic [15:0]    addr;
	logic [1:0]     n_ops;
	logic           emit;
	osd_pkg::rec_t  rec_d;
	logic [1:0]     pending_d;
	osd_pkg::mnem_t held_mn_d;
	osd_pkg::mode_t held_mode_d;
	logic [7:0]     held_low_d;
	logic [15:0]    held_addr_d;

	logic           out_valid_q;
	osd_pkg::rec_t  rec_q;

	assign advance   = !out_valid_q || !rec_stall;
	assign rec_valid = out_valid_q;
	assign rec       = rec_q;

	always_comb begin
		pend_eff    = item_s1.run_start ? 2'd0 : pending_q;
		addr        = item_s1.run_start ? start_address : next_addr_q;
		n_ops       = osd_pkg::operand_count(dec_s1.mode);
		emit        = 1'b0;
		pending_d   = 2'd0;
		held_mn_d   = held_mn_q;
		held_mode_d = held_mode_q;
		held_low_d  = held_low_q;
		held_addr_d = held_addr_q;
		rec_d.opcode_address = held_addr_q;
		rec_d.mnem           = held_mn_q;
		rec_d.mode           = held_mode_q;
		rec_d.argument       = {8'h00, item_s1.code_byte};
		rec_d.truncated      = 1'b0;
		case (pend_eff)
			2'd2: begin
				held_low_d = item_s1.code_byte;
				if (item_s1.run_end) begin
					emit            = 1'b1;
					rec_d.truncated = 1'b1;
				end else begin
					pending_d = 2'd1;
				end
			end
			2'd1: begin
				emit = 1'b1;
				if (osd_pkg::operand_count(held_mode_q) == 2'd2) begin
					rec_d.argument = {item_s1.code_byte, held_low_q};
				end
			end
			default: begin
				held_addr_d          = addr;
				rec_d.opcode_address = addr;
				rec_d.mnem           = dec_s1.mnem;
				rec_d.mode           = dec_s1.mode;
				if (!dec_s1.legal) begin
					emit = 1'b1;
				end else if (n_ops == 2'd0) begin
					emit           = 1'b1;
					rec_d.argument = 16'h0000;
				end else begin
					held_mn_d      = dec_s1.mnem;
					held_mode_d    = dec_s1.mode;
					held_low_d     = 8'h00;
					rec_d.argument = 16'h0000;
					if (item_s1.run_end) begin
						emit            = 1'b1;
						rec_d.truncated = 1'b1;
					end else begin
						pending_d = n_ops;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= 2'd0;
			held_mn_q   <= osd_pkg::MN_ADC;
			held_mode_q <= osd_pkg::AM_IMPLIED;
			held_low_q  <= 8'h00;
			next_addr_q <= 16'h0000;
			held_addr_q <= 16'h0000;
		end else if (valid_s1 && advance) begin
			pending_q   <= pending_d;
			held_mn_q   <= held_mn_d;
			held_mode_q <= held_mode_d;
			held_low_q  <= held_low_d;
			next_addr_q <= addr + 16'd1;
			held_addr_q <= held_addr_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			rec_q <= rec_d;
		end
	end

	`OSD_ASSERT_NOW(a_invalid_is_plain, clk, arst_n,
		out_valid_q && rec_q.mnem == osd_pkg::MN_INVALID,
		rec_q.mode == osd_pkg::AM_IMPLIED && !rec_q.truncated,
		"invalid opcode record carries a mode or truncation")
	`OSD_ASSERT_NEXT(a_last_operand_emits, clk, arst_n,
		valid_s1 && advance && pend_eff == 2'd1,
		out_valid_q,
		"last operand byte did not produce a record")
	`OSD_ASSERT_NOW(a_two_pending_abs, clk, arst_n,
		pending_q == 2'd2,
		osd_pkg::operand_count(held_mode_q) == 2'd2,
		"two bytes pending for a one-operand mode")
	`OSD_ASSERT_NOW(a_pending_range, clk, arst_n,
		pending_q != 2'd0,
		pending_q != 2'd3 && held_mn_q != osd_pkg::MN_INVALID,
		"operand wait without a legal opcode")

endmodule

// ===== src/opcode_stream_disassembler.sv =====
// ----------------------------------------------------------------------------
// opcode_stream_disassembler
// Splits a 6502 code byte stream into instruction records.
//
//   channel  direction  handshake               payload
//   byte     in         byte_valid / byte_stall code_byte, run_start, run_end
//   rec      out        rec_valid / rec_stall   opcode_address, mnemonic,
//                                               address_mode, argument, truncated
//   cfg      in         cfg_valid / cfg_ready   cfg_data (start_address)
//
// One byte per cycle sustained while rec_stall is low; a record's last byte and
// its ROM decode are registered in stage 1 at its transfer, and the record then
// passes to the result register when stage 1 advances.
// Reset clears the sequencer, the pipeline and start_address.
// rec_stall holds the result register and, while stage 1 and the result
// register are both full, reaches byte_stall in the same cycle. cfg_ready is
// always high.
// ----------------------------------------------------------------------------
module opcode_stream_disassembler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  code_byte,
	input  logic        run_start,
	input  logic        run_end,
	output logic        rec_valid,
	input  logic        rec_stall,
	output logic [15:0] opcode_address,
	output logic [5:0]  mnemonic,
	output logic [3:0]  address_mode,
	output logic [15:0] argument,
	output logic        truncated,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic             accept;
	logic             advance;
	logic             valid_s1;
	osd_pkg::item_t   item_s1;
	osd_pkg::decode_t dec_s1;
	osd_pkg::rec_t    rec;
	logic [15:0]      start_q;

	assign cfg_ready  = 1'b1;
	assign byte_stall = valid_s1 && !advance;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 16'h0000;
		end else if (cfg_valid && cfg_ready) begin
			start_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{code_byte, run_start, run_end};
		end
	end

	osd_decode_rom u_rom (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (code_byte),
		.rd_data (dec_s1)
	);

	osd_record_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start_address (start_q),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1),
		.dec_s1        (dec_s1),
		.advance       (advance),
		.rec_valid     (rec_valid),
		.rec_stall     (rec_stall),
		.rec           (rec)
	);

	assign opcode_address = rec.opcode_address;
	assign mnemonic       = rec.mnem;
	assign address_mode   = rec.mode;
	assign argument       = rec.argument;
	assign truncated      = rec.truncated;

endmodule
